// ===== design/lda_pkg.sv =====
`timescale 1ns / 1ps
// shared widths, reset values and register index codes for the led drive auto gain unit
// no dependencies

package lda_pkg;

    localparam int SAMPLE_W  = 19;
    localparam int RAW_W     = 24;
    localparam int CODE_W    = 8;
    localparam int PROD_W    = SAMPLE_W + CODE_W;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W     = SAMPLE_W;

    localparam logic [SAMPLE_W-1:0] LOW_THR_RST  = SAMPLE_W'(200000);
    localparam logic [SAMPLE_W-1:0] HIGH_THR_RST = SAMPLE_W'(300000);
    localparam logic [SAMPLE_W-1:0] TARGET_RST   = SAMPLE_W'(250000);
    localparam logic [CODE_W-1:0]   CEIL_RST     = 8'hFF;
    localparam logic [CODE_W-1:0]   FLOOR_RST    = 8'h02;
    localparam logic [CODE_W-1:0]   RED_CUR_RST  = 8'h50;
    localparam logic [CODE_W-1:0]   IR_CUR_RST   = 8'h15;
    localparam logic [CODE_W-1:0]   CODE_MAX     = 8'hFF;

    localparam logic [CFG_IDX_W-1:0] CFG_LOW_THR  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HIGH_THR = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CEIL     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_FLOOR    = 3'd4;

    // handshake between the sequencer and a serial arithmetic unit
    typedef struct packed {
        logic start;
    } t_unit_ctl;

    typedef struct packed {
        logic done;
    } t_unit_sts;

endpackage

// ===== design/lda_in_if.sv =====
`timescale 1ns / 1ps
// request channel carrying one raw sensor word for one led channel
// depends on lda_pkg

interface lda_in_if;
    logic                          valid;
    logic                          ready;
    logic                          channel;
    logic [lda_pkg::RAW_W-1:0]     raw_word;

    modport source (output valid, output channel, output raw_word, input ready);
    modport sink   (input valid, input channel, input raw_word, output ready);
endinterface

// ===== design/lda_out_if.sv =====
`timescale 1ns / 1ps
// result channel carrying the sample, the drive current and the changed flag
// depends on lda_pkg

interface lda_out_if;
    logic                          valid;
    logic                          ready;
    logic                          channel_out;
    logic [lda_pkg::SAMPLE_W-1:0]  sample_out;
    logic [lda_pkg::CODE_W-1:0]    drive_current;
    logic                          changed;

    modport source (output valid, output channel_out, output sample_out,
                    output drive_current, output changed, input ready);
    modport sink   (input valid, input channel_out, input sample_out,
                    input drive_current, input changed, output ready);
endinterface

// ===== design/led_drive_auto_gain_unit.sv =====
`timescale 1ns / 1ps
// led drive auto gain: one request in flight, serial multiply, serial divide
// a request that needs a computed correction passes through S_MUL and S_DIV to S_DONE, any other
// goes straight to S_DONE; S_DONE waits while the output register holds an untaken result, and
// a new request is taken only after S_DONE has loaded the result into the output register
// a finished result sits in the output register while the next request is taken
// synchronous active-low reset restores the threshold, target, ceiling and floor registers and both drive currents
// depends on lda_pkg, lda_in_if, lda_out_if, lda_mul, lda_div

module led_drive_auto_gain_unit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [lda_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [lda_pkg::CFG_W-1:0]       i_cfg_data,
    lda_in_if.sink                          i_in,
    lda_out_if.source                       o_out
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_MUL  = 4'b0010,
        S_DIV  = 4'b0100,
        S_DONE = 4'b1000
    } t_state;

    t_state r_state, n_state;

    logic [lda_pkg::SAMPLE_W-1:0] r_low_thr, r_high_thr, r_target;
    logic [lda_pkg::CODE_W-1:0]   r_ceil, r_floor;
    logic [lda_pkg::CODE_W-1:0]   r_led_cur [2];

    logic                         r_ch;
    logic [lda_pkg::SAMPLE_W-1:0] r_sample;
    logic [lda_pkg::CODE_W-1:0]   r_cur;
    logic                         r_change, r_raise, r_zero;

    logic                         r_out_valid;
    logic                         r_out_ch;
    logic [lda_pkg::SAMPLE_W-1:0] r_out_sample;
    logic [lda_pkg::CODE_W-1:0]   r_out_cur;
    logic                         r_out_changed;

    logic                         in_fire, out_fire, slot_free, done_load;
    logic [lda_pkg::SAMPLE_W-1:0] in_sample;
    logic [lda_pkg::CODE_W-1:0]   in_cur, n_cur, q8;
    logic                         in_raise, in_lower, q_sat;

    lda_pkg::t_unit_ctl           mul_ctl, div_ctl;
    lda_pkg::t_unit_sts           mul_sts, div_sts;
    logic [lda_pkg::PROD_W-1:0]   product, quotient;

    assign in_fire   = i_in.valid && i_in.ready;
    assign out_fire  = r_out_valid && o_out.ready;
    assign slot_free = !r_out_valid || o_out.ready;
    assign done_load = (r_state == S_DONE) && slot_free;

    assign in_sample = i_in.raw_word[lda_pkg::SAMPLE_W-1:0];
    assign in_cur    = r_led_cur[i_in.channel];
    assign in_raise  = (in_sample < r_low_thr) && (in_cur < r_ceil);
    assign in_lower  = (in_sample > r_high_thr) && (in_cur > r_floor);

    assign mul_ctl.start = in_fire && (in_raise || in_lower) && (in_sample != '0);
    assign div_ctl.start = (r_state == S_MUL) && mul_sts.done;

    lda_mul u_mul (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (mul_ctl),
        .i_code    (in_cur),
        .i_level   (r_target),
        .o_sts     (mul_sts),
        .o_product (product)
    );

    lda_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (div_ctl),
        .i_dividend (product),
        .i_divisor  (r_sample),
        .o_sts      (div_sts),
        .o_quotient (quotient)
    );

    // saturation and clamp of the quotient
    assign q_sat = |quotient[lda_pkg::PROD_W-1:lda_pkg::CODE_W];
    assign q8    = quotient[lda_pkg::CODE_W-1:0];

    always_comb begin
        if (!r_change) begin
            n_cur = r_cur;
        end else if (r_raise) begin
            if (r_zero || q_sat || (q8 > r_ceil)) begin
                n_cur = r_ceil;
            end else begin
                n_cur = q8;
            end
        end else begin
            if (q_sat) begin
                n_cur = lda_pkg::CODE_MAX;
            end else if (q8 < r_floor) begin
                n_cur = r_floor;
            end else begin
                n_cur = q8;
            end
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    n_state = mul_ctl.start ? S_MUL : S_DONE;
                end
            end
            S_MUL: begin
                if (mul_sts.done) begin
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                if (div_sts.done) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (slot_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_low_thr  <= lda_pkg::LOW_THR_RST;
            r_high_thr <= lda_pkg::HIGH_THR_RST;
            r_target   <= lda_pkg::TARGET_RST;
            r_ceil     <= lda_pkg::CEIL_RST;
            r_floor    <= lda_pkg::FLOOR_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                lda_pkg::CFG_LOW_THR:  r_low_thr  <= i_cfg_data;
                lda_pkg::CFG_HIGH_THR: r_high_thr <= i_cfg_data;
                lda_pkg::CFG_TARGET:   r_target   <= i_cfg_data;
                lda_pkg::CFG_CEIL:     r_ceil     <= i_cfg_data[lda_pkg::CODE_W-1:0];
                lda_pkg::CFG_FLOOR:    r_floor    <= i_cfg_data[lda_pkg::CODE_W-1:0];
                default: ;
            endcase
        end
    end

    // per-channel drive current
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_led_cur[0] <= lda_pkg::RED_CUR_RST;
            r_led_cur[1] <= lda_pkg::IR_CUR_RST;
        end else if (done_load) begin
            r_led_cur[r_ch] <= n_cur;
        end
    end

    // request being worked on
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_ch     <= i_in.channel;
            r_sample <= in_sample;
            r_cur    <= in_cur;
            r_change <= in_raise || in_lower;
            r_raise  <= in_raise;
            r_zero   <= (in_sample == '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (done_load) begin
            r_out_valid <= 1'b1;
        end else if (out_fire) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (done_load) begin
            r_out_ch      <= r_ch;
            r_out_sample  <= r_sample;
            r_out_cur     <= n_cur;
            r_out_changed <= r_change;
        end
    end

    assign i_in.ready          = (r_state == S_IDLE);
    assign o_out.valid         = r_out_valid;
    assign o_out.channel_out   = r_out_ch;
    assign o_out.sample_out    = r_out_sample;
    assign o_out.drive_current = r_out_cur;
    assign o_out.changed       = r_out_changed;

endmodule

// ===== design/lda_mul.sv =====
`timescale 1ns / 1ps
// serial-parallel multiplier: one bit of the current code per cycle, 19-bit add
// depends on lda_pkg

module lda_mul (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  lda_pkg::t_unit_ctl            i_ctl,
    input  logic [lda_pkg::CODE_W-1:0]    i_code,
    input  logic [lda_pkg::SAMPLE_W-1:0]  i_level,
    output lda_pkg::t_unit_sts            o_sts,
    output logic [lda_pkg::PROD_W-1:0]    o_product
);

    localparam int CNT_W = $clog2(lda_pkg::CODE_W);

    logic                          r_busy;
    logic [CNT_W-1:0]              r_cnt;
    logic [lda_pkg::SAMPLE_W-1:0]  r_hi;
    logic [lda_pkg::CODE_W-1:0]    r_lo;
    logic [lda_pkg::SAMPLE_W-1:0]  r_level;
    logic [lda_pkg::SAMPLE_W:0]    n_sum;
    logic                          r_done;

    always_comb begin
        n_sum = {1'b0, r_hi}
              + (r_lo[0] ? {1'b0, r_level} : '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_ctl.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(lda_pkg::CODE_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // product shifts right, the multiplier bits leave through the low end
    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_hi    <= '0;
            r_lo    <= i_code;
            r_level <= i_level;
        end else if (r_busy) begin
            r_hi <= n_sum[lda_pkg::SAMPLE_W:1];
            r_lo <= {n_sum[0], r_lo[lda_pkg::CODE_W-1:1]};
        end
    end

    assign o_sts.done = r_done;
    assign o_product  = {r_hi, r_lo};

endmodule

// ===== design/lda_div.sv =====
`timescale 1ns / 1ps
// restoring divider: one quotient bit per cycle, remainder as wide as the divisor
// depends on lda_pkg

module lda_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  lda_pkg::t_unit_ctl            i_ctl,
    input  logic [lda_pkg::PROD_W-1:0]    i_dividend,
    input  logic [lda_pkg::SAMPLE_W-1:0]  i_divisor,
    output lda_pkg::t_unit_sts            o_sts,
    output logic [lda_pkg::PROD_W-1:0]    o_quotient
);

    localparam int CNT_W = $clog2(lda_pkg::PROD_W);

    logic                          r_busy;
    logic                          r_done;
    logic [CNT_W-1:0]              r_cnt;
    logic [lda_pkg::SAMPLE_W-1:0]  r_rem;
    logic [lda_pkg::SAMPLE_W-1:0]  r_dsr;
    logic [lda_pkg::PROD_W-1:0]    r_dq;
    logic [lda_pkg::SAMPLE_W:0]    n_shift;
    logic [lda_pkg::SAMPLE_W+1:0]  n_diff;

    always_comb begin
        n_shift = {r_rem, r_dq[lda_pkg::PROD_W-1]};
        n_diff  = {1'b0, n_shift} - {2'b00, r_dsr};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_ctl.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(lda_pkg::PROD_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // dividend bits shift out the top while quotient bits shift in below
    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_rem <= '0;
            r_dsr <= i_divisor;
            r_dq  <= i_dividend;
        end else if (r_busy) begin
            if (n_diff[lda_pkg::SAMPLE_W+1]) begin
                r_rem <= n_shift[lda_pkg::SAMPLE_W-1:0];
            end else begin
                r_rem <= n_diff[lda_pkg::SAMPLE_W-1:0];
            end
            r_dq <= {r_dq[lda_pkg::PROD_W-2:0], ~n_diff[lda_pkg::SAMPLE_W+1]};
        end
    end

    assign o_sts.done = r_done;
    assign o_quotient = r_dq;

endmodule
